/* rtl/blkdg_pkg.sv */
// Shared types and codes for the block-diagonal gradient entry unit.
package blkdg_pkg;

  localparam int unsigned IDX_FW = 6;   // width of the row / col fields
  localparam int unsigned CFG_W  = 7;   // width of a configuration register
  localparam int unsigned ACC_W  = 54;  // 48-bit terms summed over up to 64 rows

  typedef enum logic [2:0] {
    ACT_LD_INV  = 3'd0,
    ACT_LD_TGT  = 3'd1,
    ACT_LD_DIAG = 3'd2,
    ACT_LD_FPW  = 3'd3,
    ACT_QUERY   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_CLASS_COUNT = 2'd0,
    CFG_CLASS_SIZE  = 2'd1
  } cfg_index_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [IDX_FW-1:0]  row;
    logic [IDX_FW-1:0]  col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic               wr_inv;
    logic               wr_tgt;
    logic               wr_diag;
    logic               wr_fpw;
    logic [IDX_FW-1:0]  row;
    logic [IDX_FW-1:0]  col;
    logic signed [31:0] value;
    logic               acc_clr;
    logic               issue;
    logic [IDX_FW-1:0]  k;
    logic               out_load;
    logic               out_from_acc;
    logic [1:0]         out_status;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } dp_sts_t;

endpackage

/* rtl/blkdg_ram.sv */
// Generic RAM: one write port, two registered read ports.
module blkdg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* rtl/blkdg_datapath.sv */
// Datapath: stores, multiply-accumulate pipeline and output register.
module blkdg_datapath #(
  parameter int unsigned MAX_N = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  blkdg_pkg::ctl_cmd_t  cmd_i,
  output blkdg_pkg::dp_sts_t   sts_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output blkdg_pkg::out_item_t out_data_o
);
  import blkdg_pkg::*;

  localparam int unsigned DIM_N     = (MAX_N < 64) ? MAX_N : 64;
  localparam int unsigned IDX_W     = $clog2(DIM_N);
  localparam int unsigned INV_DEPTH = DIM_N * (1 << IDX_W);

  localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

  function automatic logic ovf32(input logic signed [63:0] x);
    ovf32 = (x > Q_MAX) || (x < Q_MIN);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > Q_MAX) begin
      r = 32'sh7fffffff;
    end else if (x < Q_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    sat32 = r;
  endfunction

  logic [IDX_W-1:0] row_idx, col_idx, k_idx;
  assign row_idx = cmd_i.row[IDX_W-1:0];
  assign col_idx = cmd_i.col[IDX_W-1:0];
  assign k_idx   = cmd_i.k[IDX_W-1:0];

  logic [31:0] inv_a, inv_b, y_r, y_c, diag_k, fpw_k, diag_nc, fpw_nc;

  blkdg_ram #(.WIDTH(32), .DEPTH(INV_DEPTH)) u_inv_ram (
    .clk_i,
    .we_i      (cmd_i.wr_inv),
    .waddr_i   ({row_idx, col_idx}),
    .wdata_i   (cmd_i.value),
    .raddr_a_i ({k_idx, row_idx}),
    .raddr_b_i ({k_idx, col_idx}),
    .rdata_a_o (inv_a),
    .rdata_b_o (inv_b)
  );

  blkdg_ram #(.WIDTH(32), .DEPTH(DIM_N)) u_tgt_ram (
    .clk_i,
    .we_i      (cmd_i.wr_tgt),
    .waddr_i   (row_idx),
    .wdata_i   (cmd_i.value),
    .raddr_a_i (row_idx),
    .raddr_b_i (col_idx),
    .rdata_a_o (y_r),
    .rdata_b_o (y_c)
  );

  blkdg_ram #(.WIDTH(32), .DEPTH(DIM_N)) u_diag_ram (
    .clk_i,
    .we_i      (cmd_i.wr_diag),
    .waddr_i   (row_idx),
    .wdata_i   (cmd_i.value),
    .raddr_a_i (k_idx),
    .raddr_b_i (k_idx),
    .rdata_a_o (diag_k),
    .rdata_b_o (diag_nc)
  );

  blkdg_ram #(.WIDTH(32), .DEPTH(DIM_N)) u_fpw_ram (
    .clk_i,
    .we_i      (cmd_i.wr_fpw),
    .waddr_i   (row_idx),
    .wdata_i   (cmd_i.value),
    .raddr_a_i (k_idx),
    .raddr_b_i (k_idx),
    .rdata_a_o (fpw_k),
    .rdata_b_o (fpw_nc)
  );

  // pipeline valids: v1 RAM data, v2 products, v3 d term, v4 w*d
  logic v1_q, v2_q, v3_q, v4_q;
  logic signed [63:0] p1_q, p2_q, prod_q;
  logic signed [31:0] w1_q, w2_q, d_q;
  logic signed [ACC_W-1:0] acc_q;
  logic sat_q;

  logic signed [33:0] w_full;
  logic signed [47:0] s1, s2;
  logic signed [48:0] d_full;
  logic w_ovf, d_ovf;

  assign w_full = 34'(signed'(diag_k)) - {{1{fpw_k[31]}}, fpw_k, 1'b0};
  assign w_ovf  = ovf32(64'(w_full));
  assign s1     = 48'(p1_q >>> 16);
  assign s2     = (cmd_i.row != cmd_i.col) ? 48'(p2_q >>> 16) : '0;
  assign d_full = 49'(s1) + 49'(s2);
  assign d_ovf  = ovf32(64'(d_full));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      p1_q <= signed'(inv_a) * signed'(y_c);
      p2_q <= signed'(inv_b) * signed'(y_r);
      w1_q <= sat32(64'(w_full));
    end
    if (v2_q) begin
      d_q  <= sat32(64'(d_full));
      w2_q <= w1_q;
    end
    if (v3_q) begin
      prod_q <= w2_q * d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      sat_q <= 1'b0;
    end else if (cmd_i.acc_clr) begin
      acc_q <= '0;
      sat_q <= 1'b0;
    end else begin
      if (v4_q) begin
        acc_q <= acc_q + ACC_W'(prod_q >>> 16);
      end
      if ((v1_q && w_ovf) || (v2_q && d_ovf)) begin
        sat_q <= 1'b1;
      end
    end
  end

  // output register
  logic      out_valid_q;
  out_item_t out_q;
  logic      acc_ovf;

  assign acc_ovf = ovf32(64'(acc_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.out_from_acc) begin
        out_q.result_value <= sat32(64'(acc_q));
        out_q.status       <= (sat_q || acc_ovf) ? ST_SAT : ST_OK;
      end else begin
        out_q.result_value <= '0;
        out_q.status       <= cmd_i.out_status;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign sts_o.pipe_busy = v1_q | v2_q | v3_q | v4_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

/* rtl/blkdg_ctrl.sv */
// Controller: configuration registers, item decode and the row walk sequencer.
module blkdg_ctrl #(
  parameter int unsigned MAX_N = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  blkdg_pkg::in_item_t      in_data_i,
  input  logic                     cfg_valid_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [blkdg_pkg::CFG_W-1:0] cfg_data_i,
  output blkdg_pkg::ctl_cmd_t      cmd_o,
  input  blkdg_pkg::dp_sts_t       sts_i
);
  import blkdg_pkg::*;

  localparam int unsigned DIM_N = (MAX_N < 64) ? MAX_N : 64;
  localparam int unsigned IDX_W = $clog2(DIM_N);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]       state_q, state_d;
  in_item_t         op_q;
  logic [CFG_W-1:0] count_q, size_q;
  logic [IDX_W-1:0] k_q, k_d, nlast_q, nlast_d;
  logic [IDX_W-1:0] pos_q, pos_d, blk_q, blk_d, rid_q, rid_d, cid_q, cid_d;
  logic             rsp_acc_q, rsp_acc_d;
  logic [1:0]       rsp_st_q, rsp_st_d;

  logic [13:0] n_w;
  logic        ld_bad, q_bad;

  assign n_w    = {7'b0, count_q} * {7'b0, size_q};
  assign ld_bad = (32'(op_q.row) >= MAX_N) ||
                  ((op_q.action == ACT_LD_INV) && (32'(op_q.col) >= MAX_N));
  assign q_bad  = (count_q == '0) || (size_q == '0) || (n_w > 14'(MAX_N)) ||
                  (n_w > 14'd64) || (14'(op_q.row) >= n_w) || (14'(op_q.col) >= n_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CFG_W'(1);
      size_q  <= CFG_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CLASS_COUNT: count_q <= cfg_data_i;
        CFG_CLASS_SIZE:  size_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    nlast_d   = nlast_q;
    pos_d     = pos_q;
    blk_d     = blk_q;
    rid_d     = rid_q;
    cid_d     = cid_q;
    rsp_acc_d = rsp_acc_q;
    rsp_st_d  = rsp_st_q;

    cmd_o              = '0;
    cmd_o.row          = op_q.row;
    cmd_o.col          = op_q.col;
    cmd_o.value        = op_q.value;
    cmd_o.k            = IDX_FW'(k_q);
    cmd_o.out_from_acc = rsp_acc_q;
    cmd_o.out_status   = rsp_st_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        rsp_acc_d = 1'b0;
        rsp_st_d  = ST_RANGE;
        state_d   = S_RESP;
        case (op_q.action)
          ACT_LD_INV, ACT_LD_TGT, ACT_LD_DIAG, ACT_LD_FPW: begin
            if (!ld_bad) begin
              rsp_st_d      = ST_OK;
              cmd_o.wr_inv  = (op_q.action == ACT_LD_INV);
              cmd_o.wr_tgt  = (op_q.action == ACT_LD_TGT);
              cmd_o.wr_diag = (op_q.action == ACT_LD_DIAG);
              cmd_o.wr_fpw  = (op_q.action == ACT_LD_FPW);
            end
          end
          ACT_QUERY: begin
            if (!q_bad) begin
              cmd_o.acc_clr = 1'b1;
              k_d           = '0;
              pos_d         = '0;
              blk_d         = '0;
              nlast_d       = IDX_W'(n_w - 14'd1);
              state_d       = S_RUN;
            end
          end
          default: ;
        endcase
      end
      S_RUN: begin
        cmd_o.issue = 1'b1;
        // block number of each walked row, caught where it meets i and j
        if (IDX_FW'(k_q) == op_q.row) begin
          rid_d = blk_q;
        end
        if (IDX_FW'(k_q) == op_q.col) begin
          cid_d = blk_q;
        end
        if (CFG_W'(pos_q) == size_q - CFG_W'(1)) begin
          pos_d = '0;
          blk_d = blk_q + IDX_W'(1);
        end else begin
          pos_d = pos_q + IDX_W'(1);
        end
        k_d = k_q + IDX_W'(1);
        if (k_q == nlast_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          rsp_acc_d = (rid_q == cid_q);
          rsp_st_d  = ST_OK;
          state_d   = S_RESP;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q <= in_data_i;
    end
    k_q       <= k_d;
    nlast_q   <= nlast_d;
    pos_q     <= pos_d;
    blk_q     <= blk_d;
    rid_q     <= rid_d;
    cid_q     <= cid_d;
    rsp_acc_q <= rsp_acc_d;
    rsp_st_q  <= rsp_st_d;
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

/* rtl/block_diag_gradient_entry_unit.sv */
// Top level of the block-diagonal gradient entry unit.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, in_data_i        | item in
//  out     | out_valid_o, out_ready_i, out_data_o     | result out
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i,   | register write
//          | cfg_data_i                               |
//
// Loads and rejected items pass through the execute and respond states to the
// result register; a query in range (N = class_count * class_size) walks one
// row k per cycle through the inverse-matrix RAM, then waits for the
// multiply-accumulate pipeline to drain before the respond state. The unit
// takes the next beat once the result is loaded, and an item holds it longer
// while the result register stays full. One item is in work at a time.
// Reset clears control state only; store contents are undefined until loaded.
module block_diag_gradient_entry_unit #(
  parameter int unsigned MAX_N = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  blkdg_pkg::in_item_t         in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output blkdg_pkg::out_item_t        out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [blkdg_pkg::CFG_W-1:0] cfg_data_i
);
  import blkdg_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  assign cfg_ready_o = 1'b1;

  blkdg_ctrl #(.MAX_N(MAX_N)) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .cmd_o (cmd),
    .sts_i (sts)
  );

  blkdg_datapath #(.MAX_N(MAX_N)) u_datapath (
    .clk_i,
    .rst_ni,
    .cmd_i (cmd),
    .sts_o (sts),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

endmodule
